@@ rtl/prw_pkg.sv @@
package prw_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PRIO_BITS   = 8;
  localparam int TAG_W       = 4;
  localparam int NUM_TAGS    = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_YIELD   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_RELEASE = 2'd1;
  localparam logic [1:0] ST_QUEUE_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD_YIELD   = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [PRIO_BITS-1:0] prio;
    logic                 wr;
  } entry_t;

  // Shift commands broadcast to every cell of the wait queue.
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_op_t;

endpackage

@@ rtl/prw_cell.sv @@
module prw_cell (
  input  logic               clk,
  input  prw_pkg::cell_op_t  op,
  input  prw_pkg::entry_t    ins,
  input  logic               valid,
  input  logic [3:0]         qtag,
  input  prw_pkg::entry_t    left,
  input  logic               left_gt,
  input  prw_pkg::entry_t    right,
  output prw_pkg::entry_t    entry,
  output logic               gt,
  output logic               match
);

  // An empty slot counts as ranked after the new entry, so the insertion
  // point is the first cell that raises gt while its left neighbor does not.
  assign gt    = !valid || (entry.prio > ins.prio);
  assign match = valid && (entry.tag == qtag);

  always_ff @(posedge clk) begin
    if (op.pop) begin
      entry <= right;
    end else if (op.insert) begin
      if (left_gt) begin
        entry <= left;
      end else if (gt) begin
        entry <= ins;
      end
    end
  end

endmodule

@@ rtl/prw_ctrl.sv @@
module prw_ctrl (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [15:0]                             s_tdata,
  input  logic [1:0]                              s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [23:0]                             m_tdata,
  output logic                                    m_tuser,
  output logic                                    m_tlast,
  input  logic [prw_pkg::QUEUE_DEPTH-1:0]         match,
  input  prw_pkg::entry_t                         head,
  output prw_pkg::cell_op_t                       op,
  output prw_pkg::entry_t                         ins,
  output logic [prw_pkg::TAG_W-1:0]               qtag,
  output logic [prw_pkg::CNT_W-1:0]               count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GRANT,
    S_STATUS
  } state_t;

  state_t                               state;
  logic [1:0]                           cmd_q;
  logic [prw_pkg::TAG_W-1:0]            tag_q;
  logic [prw_pkg::PRIO_BITS-1:0]        prio_q;
  logic                                 wr_q;
  logic [prw_pkg::NUM_TAGS-1:0]         holder_mask;
  logic                                 writer_holds;
  logic [prw_pkg::PRIO_BITS-1:0]        attr_prio [prw_pkg::NUM_TAGS];
  logic [prw_pkg::NUM_TAGS-1:0]         attr_wr;
  logic [1:0]                           status_q;
  logic [4:0]                           position_q;

  logic [prw_pkg::TAG_W-1:0]            out_tag;
  logic                                 out_wr;
  logic [1:0]                           out_status;
  logic [4:0]                           out_qlen;
  logic [4:0]                           out_pos;

  logic                                 held;
  logic                                 found;
  logic                                 full;
  logic                                 do_ins;
  logic                                 do_free;
  logic [1:0]                           exec_status;
  logic                                 eligible;
  logic                                 slot_free;
  logic                                 grant_go;
  logic                                 out_load;
  logic [prw_pkg::IDX_W-1:0]            match_idx;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {7'd0, out_pos, out_qlen, out_status, out_wr, out_tag};
  assign qtag     = tag_q;

  always_comb begin
    held      = holder_mask[tag_q];
    found     = |match;
    full      = (count == prw_pkg::CNT_W'(prw_pkg::QUEUE_DEPTH));
    slot_free = !m_tvalid || m_tready;
    eligible  = head.wr ? (holder_mask == '0) : !writer_holds;
    grant_go  = (count != '0) && eligible && slot_free;
    out_load  = ((state == S_GRANT) && grant_go) || ((state == S_STATUS) && slot_free);

    match_idx = '0;
    for (int i = 0; i < prw_pkg::QUEUE_DEPTH; i++) begin
      if (match[i]) begin
        match_idx = match_idx | prw_pkg::IDX_W'(i);
      end
    end

    ins.tag  = tag_q;
    ins.prio = (cmd_q == prw_pkg::CMD_REQUEST) ? prio_q : attr_prio[tag_q];
    ins.wr   = (cmd_q == prw_pkg::CMD_REQUEST) ? wr_q : attr_wr[tag_q];

    do_ins      = 1'b0;
    do_free     = 1'b0;
    exec_status = prw_pkg::ST_OK;
    case (cmd_q)
      prw_pkg::CMD_REQUEST: begin
        // A tag that already waits or holds is ignored.
        if (!held && !found) begin
          if (full) begin
            exec_status = prw_pkg::ST_QUEUE_FULL;
          end else begin
            do_ins = 1'b1;
          end
        end
      end
      prw_pkg::CMD_YIELD: begin
        if (!held) begin
          exec_status = prw_pkg::ST_BAD_YIELD;
        end else if (full) begin
          exec_status = prw_pkg::ST_QUEUE_FULL;
        end else begin
          do_ins  = 1'b1;
          do_free = 1'b1;
        end
      end
      prw_pkg::CMD_RELEASE: begin
        if (!held) begin
          exec_status = prw_pkg::ST_BAD_RELEASE;
        end else begin
          do_free = 1'b1;
        end
      end
      default: begin
      end
    endcase

    op.insert = (state == S_EXEC) && do_ins;
    op.pop    = (state == S_GRANT) && grant_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      holder_mask  <= '0;
      writer_holds <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q  <= s_tuser;
            tag_q  <= s_tdata[prw_pkg::TAG_W-1:0];
            prio_q <= s_tdata[4 +: prw_pkg::PRIO_BITS];
            wr_q   <= s_tdata[12];
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_q   <= exec_status;
          position_q <= (cmd_q == prw_pkg::CMD_QUERY) ?
                        (found ? 5'(match_idx) : 5'(count)) : 5'd0;
          if (do_ins) begin
            count <= count + 1'b1;
            if (cmd_q == prw_pkg::CMD_REQUEST) begin
              attr_prio[tag_q] <= prio_q;
              attr_wr[tag_q]   <= wr_q;
            end
          end
          if (do_free) begin
            holder_mask[tag_q] <= 1'b0;
            if (attr_wr[tag_q]) begin
              writer_holds <= 1'b0;
            end
          end
          state <= S_GRANT;
        end
        S_GRANT: begin
          if ((count == '0) || !eligible) begin
            state <= S_STATUS;
          end else if (slot_free) begin
            count                 <= count - 1'b1;
            holder_mask[head.tag] <= 1'b1;
            if (head.wr) begin
              writer_holds <= 1'b1;
            end
            m_tuser    <= 1'b1;
            m_tlast    <= 1'b0;
            out_tag    <= head.tag;
            out_wr     <= head.wr;
            out_status <= prw_pkg::ST_OK;
            out_qlen   <= 5'(count - 1'b1);
            out_pos    <= '0;
          end
        end
        S_STATUS: begin
          if (slot_free) begin
            m_tuser    <= 1'b0;
            m_tlast    <= 1'b1;
            out_tag    <= '0;
            out_wr     <= 1'b0;
            out_status <= status_q;
            out_qlen   <= 5'(count);
            out_pos    <= position_q;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/priority_rw_lock_arbiter.sv @@
// Reader/writer lock arbiter with a priority wait queue. Each input
// transaction carries a command (request, yield, release or position query)
// in s_tuser and answers with zero or more grant transactions, in grant
// order, followed by one status transaction marked by m_tlast. The wait
// queue is a row of cells kept sorted by priority (lower first, arrival
// order among equals); an insert shifts the cells from its insertion point
// on one step and a head removal shifts every cell one step, and tag
// lookups compare all cells at once. An input is accepted, then executed;
// a grant loop then removes one queue head per cycle while the output
// slot is free, until it finds the queue empty or its head not eligible,
// and the status follows; backpressure on the result side stretches both.
// A new input is accepted only after the previous status has been loaded
// into the output register. No clearing pass runs after reset.
module priority_rw_lock_arbiter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // tag[3:0], prio[11:4], write[12]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // grant_tag[3:0], grant_write[4], status[6:5],
                                 // queue_length[11:7], position[16:12]
  output logic        m_tuser,   // is_grant[0]
  output logic        m_tlast
);

  prw_pkg::cell_op_t                    op;
  prw_pkg::entry_t                      ins;
  logic [prw_pkg::TAG_W-1:0]            qtag;
  logic [prw_pkg::CNT_W-1:0]            count;
  prw_pkg::entry_t                      entries [prw_pkg::QUEUE_DEPTH];
  logic [prw_pkg::QUEUE_DEPTH-1:0]      gt;
  logic [prw_pkg::QUEUE_DEPTH-1:0]      match;

  prw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .match    (match),
    .head     (entries[0]),
    .op       (op),
    .ins      (ins),
    .qtag     (qtag),
    .count    (count)
  );

  for (genvar i = 0; i < prw_pkg::QUEUE_DEPTH; i++) begin : g_cell
    prw_pkg::entry_t left_entry;
    prw_pkg::entry_t right_entry;
    logic            left_gt;
    logic            valid;

    assign valid = (prw_pkg::CNT_W'(i) < count);
    if (i == 0) begin : g_first
      assign left_entry = entries[i];
      assign left_gt    = 1'b0;
    end else begin : g_inner
      assign left_entry = entries[i-1];
      assign left_gt    = gt[i-1];
    end
    if (i == prw_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    prw_cell u_cell (
      .clk     (clk),
      .op      (op),
      .ins     (ins),
      .valid   (valid),
      .qtag    (qtag),
      .left    (left_entry),
      .left_gt (left_gt),
      .right   (right_entry),
      .entry   (entries[i]),
      .gt      (gt[i]),
      .match   (match[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= prw_pkg::CNT_W'(prw_pkg::QUEUE_DEPTH))
    else $error("wait queue count exceeds depth");

  a_unique_tag: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("tag found in more than one queue cell");

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(op.insert && op.pop))
    else $error("insert and pop in the same cycle");

  a_status_closes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !m_tuser)
    else $error("closing transaction is marked as a grant");

endmodule
